>>> design/ifpad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame parser package
// Shared types, codes and the angle decode function.
// ----------------------------------------------------------------------------
package ifpad_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned ANGLE_W     = 16;
   localparam int unsigned N_ANGLE_B   = 6;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PROD_W      = 25;

   localparam logic [BYTE_W-1:0] HDR_BYTE       = 8'h55;
   localparam logic [BYTE_W-1:0] ATT_ID_RESET   = 8'd1;
   localparam logic [BYTE_W-1:0] MAX_LEN_RESET  = 8'd64;
   localparam logic signed [PROD_W-1:0] DEG_SCALE = 25'sd180;

   typedef enum logic [2:0] {
      PH_HEAD1 = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_ID    = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_SUM   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_ATT_OK   = 2'd0,
      ST_OTHER_OK = 2'd1,
      ST_SUM_ERR  = 2'd2,
      ST_LEN_ERR  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTITUDE_ID = 1'd0,
      CSR_MAX_LENGTH  = 1'd1
   } csr_index_type;

   typedef struct packed {
      status_type                         status;
      logic [BYTE_W-1:0]                  src_id;
      logic [N_ANGLE_B-1:0][BYTE_W-1:0]   angle_bytes;
   } frame_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [ANGLE_W-1:0] decode_angle(input logic [BYTE_W-1:0] lo,
                                                        input logic [BYTE_W-1:0] hi);
      logic signed [PROD_W-1:0] raw;
      logic signed [PROD_W-1:0] prod;
      raw  = PROD_W'($signed({hi, lo}));
      prod = raw * DEG_SCALE;
      return prod[ANGLE_W+BYTE_W-1:BYTE_W];
   endfunction

endpackage
`default_nettype wire

>>> design/imu_frame_parser_attitude_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame parser with attitude decode
// Parses 0x55 0x55 / id / length / payload / checksum frames from a byte
// stream and returns one result transaction per checksum byte.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while req_ready is high. A frame
// record is pushed into a small queue on the checksum byte; the back end
// scales roll, pitch and yaw (raw * 180 >> 8) with one multiplier per angle
// into the output register, which raises rsp_valid. req_ready drops only
// while the record queue is full, i.e. while results are held back by
// rsp_ready. Angles are zero unless the status is attitude ok. The user must
// write configuration through csr_we/csr_index/csr_wdata only while the
// block is idle; the block itself does not enforce this.
module imu_frame_parser_attitude_decode import ifpad_pkg::*; #(
   parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [BYTE_W-1:0]         rsp_src_id,
   output logic signed [ANGLE_W-1:0] rsp_roll,
   output logic signed [ANGLE_W-1:0] rsp_pitch,
   output logic signed [ANGLE_W-1:0] rsp_yaw,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_wdata
);

   queue_stat_type q_stat;
   frame_rec_type  push_rec, head_rec;
   logic           q_push, q_pop;

   ifpad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_rec       (push_rec)
   );

   ifpad_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .pop      (q_pop),
      .head_rec (head_rec),
      .stat     (q_stat)
   );

   ifpad_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .q_rec        (head_rec),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_src_id   (rsp_src_id),
      .rsp_roll     (rsp_roll),
      .rsp_pitch    (rsp_pitch),
      .rsp_yaw      (rsp_yaw)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("record pushed into full queue");

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");

   a_angles_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_ATT_OK) |->
         (rsp_roll == '0 && rsp_pitch == '0 && rsp_yaw == '0))
      else $error("nonzero angles on non-attitude result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

>>> design/ifpad_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame parser front end
// Tracks the frame byte by byte, sums and classifies it, and pushes one
// frame record into the queue on the checksum byte.
// ----------------------------------------------------------------------------
module ifpad_front import ifpad_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_rx_byte,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_wdata,
   input  wire queue_stat_type       q_stat,
   output logic                      q_push,
   output frame_rec_type             q_rec
);

   phase_type                        phase_ff, phase_in;
   logic [BYTE_W-1:0]                sum_ff, sum_in;
   logic [BYTE_W-1:0]                count_ff, count_in;
   logic [BYTE_W-1:0]                id_ff, id_in;
   logic [BYTE_W-1:0]                len_ff, len_in;
   logic [N_ANGLE_B-1:0][BYTE_W-1:0] ang_ff, ang_in;
   logic [BYTE_W-1:0]                att_id_ff;
   logic [BYTE_W-1:0]                max_len_ff;
   logic                             accept;
   logic [BYTE_W-1:0]                count_inc;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign count_inc = count_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_id_ff  <= ATT_ID_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTITUDE_ID: att_id_ff  <= csr_wdata;
            CSR_MAX_LENGTH:  max_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         sum_ff   <= '0;
         count_ff <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
   end

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      ang_in   = ang_ff;
      q_push   = 1'b0;
      q_rec.src_id      = id_ff;
      q_rec.angle_bytes = '0;
      if (len_ff > max_len_ff) begin
         q_rec.status = ST_LEN_ERR;
      end else if (sum_ff != req_rx_byte) begin
         q_rec.status = ST_SUM_ERR;
      end else if (id_ff == att_id_ff) begin
         q_rec.status      = ST_ATT_OK;
         q_rec.angle_bytes = ang_ff;
      end else begin
         q_rec.status = ST_OTHER_OK;
      end
      if (accept) begin
         unique case (phase_ff)
            PH_HEAD1: begin
               if (req_rx_byte == HDR_BYTE) phase_in = PH_HEAD2;
            end
            PH_HEAD2: begin
               phase_in = (req_rx_byte == HDR_BYTE) ? PH_ID : PH_HEAD1;
            end
            PH_ID: begin
               id_in    = req_rx_byte;
               count_in = '0;
               ang_in   = '0;
               sum_in   = HDR_BYTE + HDR_BYTE + req_rx_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = req_rx_byte;
               sum_in   = sum_ff + req_rx_byte;
               phase_in = (req_rx_byte == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               if (count_ff < BYTE_W'(N_ANGLE_B)) begin
                  ang_in[count_ff[$clog2(N_ANGLE_B)-1:0]] = req_rx_byte;
               end
               sum_in   = sum_ff + req_rx_byte;
               count_in = count_inc;
               if (count_inc >= len_ff) phase_in = PH_SUM;
            end
            PH_SUM: begin
               q_push   = 1'b1;
               phase_in = PH_HEAD1;
            end
            default: phase_in = PH_HEAD1;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> design/ifpad_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame parser record queue
// Small FIFO of frame records between the parser and the angle decoder.
// ----------------------------------------------------------------------------
module ifpad_queue import ifpad_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire frame_rec_type push_rec,
   input  wire logic          pop,
   output frame_rec_type      head_rec,
   output queue_stat_type     stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   frame_rec_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_rec;
   end

endmodule
`default_nettype wire

>>> design/ifpad_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU frame parser back end
// Scales the three raw angles of a record and holds the result transaction
// in the output register.
// ----------------------------------------------------------------------------
module ifpad_back import ifpad_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_stat_type q_stat,
   input  wire frame_rec_type  q_rec,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [BYTE_W-1:0]   rsp_src_id,
   output logic [ANGLE_W-1:0]  rsp_roll,
   output logic [ANGLE_W-1:0]  rsp_pitch,
   output logic [ANGLE_W-1:0]  rsp_yaw
);

   logic               valid_ff;
   status_type         status_ff;
   logic [BYTE_W-1:0]  id_ff;
   logic [ANGLE_W-1:0] roll_ff, pitch_ff, yaw_ff;

   assign q_pop = !q_stat.empty && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= q_rec.status;
         id_ff     <= q_rec.src_id;
         roll_ff   <= decode_angle(q_rec.angle_bytes[0], q_rec.angle_bytes[1]);
         pitch_ff  <= decode_angle(q_rec.angle_bytes[2], q_rec.angle_bytes[3]);
         yaw_ff    <= decode_angle(q_rec.angle_bytes[4], q_rec.angle_bytes[5]);
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_src_id   = id_ff;
   assign rsp_roll     = roll_ff;
   assign rsp_pitch    = pitch_ff;
   assign rsp_yaw      = yaw_ff;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame parser testbench
// Streams directed and random byte sequences (good frames, corrupted
// checksums, oversized lengths, line noise and cut-off frames) into the
// parser under several register settings, predicts every result transaction
// and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
   import ifpad_pkg::*;

   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_BYTES    = 200;
   localparam int unsigned N_PHASES       = 6;

   typedef logic [BYTE_W-1:0] byte_q_type [$];

   typedef struct {
      status_type                status;
      logic [BYTE_W-1:0]         src_id;
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] yaw;
   } frame_result_type;

   class frame_scoreboard;
      logic [BYTE_W-1:0] attitude_id = ATT_ID_RESET;
      logic [BYTE_W-1:0] max_length  = MAX_LEN_RESET;
      phase_type         phase       = PH_HEAD1;
      logic [BYTE_W-1:0] frame_sum   = '0;
      logic [BYTE_W-1:0] taken       = '0;
      logic [BYTE_W-1:0] cur_id      = '0;
      logic [BYTE_W-1:0] cur_len     = '0;
      logic [BYTE_W-1:0] angle_b [N_ANGLE_B] = '{default: '0};
      frame_result_type  result_q [$];
      int unsigned       errors = 0;

      function logic signed [ANGLE_W-1:0] scale_angle(logic [BYTE_W-1:0] lo,
                                                      logic [BYTE_W-1:0] hi);
         logic signed [31:0] raw;
         logic signed [31:0] prod;
         raw  = $signed({hi, lo});
         prod = (raw * 32'sd180) >>> BYTE_W;
         return prod[ANGLE_W-1:0];
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         frame_result_type res;
         case (phase)
            PH_HEAD1: if (b == HDR_BYTE) phase = PH_HEAD2;
            PH_HEAD2: phase = (b == HDR_BYTE) ? PH_ID : PH_HEAD1;
            PH_ID: begin
               cur_id    = b;
               taken     = '0;
               foreach (angle_b[i]) angle_b[i] = '0;
               frame_sum = HDR_BYTE + HDR_BYTE + b;
               phase     = PH_LEN;
            end
            PH_LEN: begin
               cur_len   = b;
               frame_sum = frame_sum + b;
               phase     = (b == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               if (taken < N_ANGLE_B) angle_b[taken] = b;
               frame_sum = frame_sum + b;
               taken     = taken + 1'b1;
               if (taken >= cur_len) phase = PH_SUM;
            end
            PH_SUM: begin
               res.src_id   = cur_id;
               res.roll     = '0;
               res.pitch    = '0;
               res.yaw      = '0;
               if (cur_len > max_length) begin
                  res.status = ST_LEN_ERR;
               end else if (frame_sum != b) begin
                  res.status = ST_SUM_ERR;
               end else if (cur_id == attitude_id) begin
                  res.status = ST_ATT_OK;
                  res.roll   = scale_angle(angle_b[0], angle_b[1]);
                  res.pitch  = scale_angle(angle_b[2], angle_b[3]);
                  res.yaw    = scale_angle(angle_b[4], angle_b[5]);
               end else begin
                  res.status = ST_OTHER_OK;
               end
               result_q.push_back(res);
               phase = PH_HEAD1;
            end
            default: phase = PH_HEAD1;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [1:0] status, logic [BYTE_W-1:0] id,
                        logic signed [ANGLE_W-1:0] roll,
                        logic signed [ANGLE_W-1:0] pitch,
                        logic signed [ANGLE_W-1:0] yaw);
         frame_result_type want;
         if (result_q.size() == 0) begin
            report($sformatf("unexpected result, id %02h status %0d", id, status));
         end else begin
            want = result_q.pop_front();
            if (status !== want.status)
               report($sformatf("status %0d, want %0d (id %02h)", status, want.status, id));
            if (id !== want.src_id)
               report($sformatf("src_id %02h, want %02h", id, want.src_id));
            if (roll !== want.roll)
               report($sformatf("roll %0d, want %0d (id %02h)", roll, want.roll, id));
            if (pitch !== want.pitch)
               report($sformatf("pitch %0d, want %0d (id %02h)", pitch, want.pitch, id));
            if (yaw !== want.yaw)
               report($sformatf("yaw %0d, want %0d (id %02h)", yaw, want.yaw, id));
         end
      endtask
   endclass

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [BYTE_W-1:0]         req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [1:0]                rsp_status;
   logic [BYTE_W-1:0]         rsp_src_id;
   logic signed [ANGLE_W-1:0] rsp_roll;
   logic signed [ANGLE_W-1:0] rsp_pitch;
   logic signed [ANGLE_W-1:0] rsp_yaw;
   logic                      csr_we      = 1'b0;
   csr_index_type             csr_index   = CSR_ATTITUDE_ID;
   logic [BYTE_W-1:0]         csr_wdata   = '0;

   logic            quiet = 1'b0;
   int unsigned     sent  = 0;
   int unsigned     stall = 0;
   frame_scoreboard sb    = new();

   imu_frame_parser_attitude_decode i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_src_id   (rsp_src_id),
      .rsp_roll     (rsp_roll),
      .rsp_pitch    (rsp_pitch),
      .rsp_yaw      (rsp_yaw),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_src_id, rsp_roll, rsp_pitch, rsp_yaw);
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall <= 0;
      else stall <= stall + 1;
      if (stall >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      sent++;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] id, input byte_q_type payload,
                             input logic [BYTE_W-1:0] corrupt);
      logic [BYTE_W-1:0] sum;
      sum = HDR_BYTE + HDR_BYTE + id + BYTE_W'(payload.size());
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      send_byte(id);
      send_byte(BYTE_W'(payload.size()));
      foreach (payload[i]) begin
         send_byte(payload[i]);
         sum = sum + payload[i];
      end
      send_byte(sum ^ corrupt);
   endtask

   // hold the sender until every pending result transaction is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [BYTE_W-1:0] att, input logic [BYTE_W-1:0] maxl);
      csr_we    <= 1'b1;
      csr_index <= CSR_ATTITUDE_ID;
      csr_wdata <= att;
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= maxl;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.attitude_id = att;
      sb.max_length  = maxl;
   endtask

   task automatic run_random(input int unsigned n_bytes);
      byte_q_type        payload;
      int unsigned       stop;
      int unsigned       pick;
      int unsigned       pick_len;
      int unsigned       len;
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] b;
      stop = sent + n_bytes;
      while (sent < stop) begin
         pick     = $urandom_range(0, 99);
         pick_len = $urandom_range(0, 99);
         id       = ($urandom_range(0, 99) < 60) ? sb.attitude_id : BYTE_W'($urandom);
         if (pick_len < 55) len = $urandom_range(0, 7);
         else if (pick_len < 85) len = $urandom_range(6, 14);
         else if (pick_len < 97) len = sb.max_length + $urandom_range(0, 1);
         else len = $urandom_range(15, 255);
         if (len > 255) len = 255;
         if (pick < 72) begin
            payload = {};
            repeat (len) payload.push_back(BYTE_W'($urandom));
            send_frame(id, payload,
                       ($urandom_range(0, 99) < 80) ? '0 : BYTE_W'($urandom_range(1, 255)));
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : BYTE_W'($urandom));
         end else begin
            send_byte(HDR_BYTE);
            if ($urandom_range(0, 1) == 0) begin
               b = BYTE_W'($urandom);
               if (b == HDR_BYTE) b = ~b;
               send_byte(b);
            end else begin
               // cut the frame short and let the following traffic run into it
               send_byte(HDR_BYTE);
               send_byte(id);
               send_byte(BYTE_W'(len));
               repeat ($urandom_range(0, len)) send_byte(BYTE_W'($urandom));
            end
         end
      end
   endtask

   initial begin
      byte_q_type        payload;
      logic [BYTE_W-1:0] phase_att [N_PHASES];
      logic [BYTE_W-1:0] phase_max [N_PHASES];
      phase_att    = '{ATT_ID_RESET, 8'h00, 8'hFF, 8'h00, HDR_BYTE, ATT_ID_RESET};
      phase_max    = '{MAX_LEN_RESET, 8'hFF, 8'h01, 8'h01, 8'h06, MAX_LEN_RESET};
      phase_att[3] = BYTE_W'($urandom);
      phase_max[3] = BYTE_W'($urandom_range(1, 255));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bad second header, then zero length with another id
      send_byte(HDR_BYTE);
      send_byte(8'h00);
      payload = {};
      send_frame(8'h02, payload, 8'h00);
      // short attitude frame with extreme raw angles, yaw bytes missing
      payload = {8'h00, 8'h80, 8'hFF, 8'h7F};
      send_frame(ATT_ID_RESET, payload, 8'h00);
      // checksum error on an attitude id
      payload = {};
      send_frame(ATT_ID_RESET, payload, 8'hFF);
      drain();
      set_config(8'hFF, 8'h01);
      // length above the limit
      payload = {8'h12, 8'h34};
      send_frame(8'hFF, payload, 8'h00);

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         set_config(phase_att[p], phase_max[p]);
         quiet <= (p == 3);
         run_random(PHASE_BYTES);
      end
      drain();

      if (sb.errors == 0 && sb.result_q.size() == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule
